>>> rtl/core/verlet_rope_step_macros.svh
// verlet_rope_step_macros.svh: assertion macros for the rope step core
// no dependencies; expects clk_i and rst_ni in the scope of use
`ifndef VERLET_ROPE_STEP_MACROS_SVH
`define VERLET_ROPE_STEP_MACROS_SVH

// same-cycle implication
`define VRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vrs check failed");

// next-cycle implication
`define VRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vrs check failed");

`endif

>>> rtl/core/vrs_pkg.sv
// vrs_pkg: shared types, constants and helpers for the rope step core
// no dependencies
package vrs_pkg;

  localparam int NumSegmentsDefault = 10;
  localparam int PosW               = 24;
  localparam logic [7:0] GravReset  = 8'd64;
  localparam int UnitW              = 64;

  // input item operations
  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  // shared serial unit operations
  typedef enum logic [1:0] {
    UOP_MUL  = 2'd0,
    UOP_SQRT = 2'd1,
    UOP_DIV  = 2'd2
  } unit_op_e;

  typedef struct packed {
    logic             start;
    unit_op_e         op;
    logic [UnitW-1:0] a;
    logic [UnitW-1:0] b;
  } unit_req_t;

  // clamp to the signed 24-bit position range
  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [31:0] v);
    logic signed [PosW-1:0] r;
    if (v > 32'sd8388607) r = 24'sh7FFFFF;
    else if (v < -32'sd8388608) r = 24'sh800000;
    else r = v[PosW-1:0];
    return r;
  endfunction

endpackage

>>> rtl/core/vrs_serial.sv
// vrs_serial: bit-serial unsigned multiply, square root and divide unit
// depends on vrs_pkg
module vrs_serial (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vrs_pkg::unit_req_t   req_i,
  output logic                 done_o,
  output logic [vrs_pkg::UnitW-1:0] res_o
);

  logic                        busy_q;
  logic                        done_q;
  vrs_pkg::unit_op_e           op_q;
  logic [5:0]                  cnt_q;
  logic [vrs_pkg::UnitW-1:0]   x_q, y_q, acc_q, rem_q;
  logic [vrs_pkg::UnitW-1:0]   sq_t, rem_n;
  logic [5:0]                  last_cnt;

  assign last_cnt = (op_q == vrs_pkg::UOP_DIV) ? 6'd63 : 6'd31;
  assign sq_t     = acc_q + y_q;
  assign rem_n    = {rem_q[vrs_pkg::UnitW-2:0], x_q[vrs_pkg::UnitW-1]};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= vrs_pkg::UOP_MUL;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= req_i.op;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == last_cnt) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // one step of the selected operation per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      rem_q <= '0;
      x_q   <= req_i.a;
      if (req_i.op == vrs_pkg::UOP_SQRT) y_q <= 64'h4000_0000_0000_0000;
      else y_q <= req_i.b;
    end else if (busy_q) begin
      unique case (op_q)
        vrs_pkg::UOP_MUL: begin
          if (y_q[0]) acc_q <= acc_q + x_q;
          x_q <= x_q << 1;
          y_q <= y_q >> 1;
        end
        vrs_pkg::UOP_SQRT: begin
          if (x_q >= sq_t) begin
            x_q   <= x_q - sq_t;
            acc_q <= (acc_q >> 1) + y_q;
          end else begin
            acc_q <= acc_q >> 1;
          end
          y_q <= y_q >> 2;
        end
        vrs_pkg::UOP_DIV: begin
          x_q <= x_q << 1;
          if (rem_n >= y_q) begin
            rem_q <= rem_n - y_q;
            acc_q <= {acc_q[vrs_pkg::UnitW-2:0], 1'b1};
          end else begin
            rem_q <= rem_n;
            acc_q <= {acc_q[vrs_pkg::UnitW-2:0], 1'b0};
          end
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

>>> rtl/core/verlet_rope_step.sv
// verlet_rope_step: rope of particles, Verlet integration and length relaxation
// depends on vrs_pkg, vrs_serial and verlet_rope_step_macros.svh
//
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// item in  | start high, busy low       | op, particle_index, pos_x/y, head_accel_x, seg_length
// result   | out_valid_o, one cycle     | out_index, out_x/y, last_particle
// config   | gravity_accel_we_i         | gravity_accel_i
//
// a load writes one particle while the core stays idle; a tick runs the Verlet update of
// all N+1 particles, then N+1 relaxation passes over the N segments, then reports
// all N+1 particles (N = NUM_SEGMENTS)
// each segment update runs on the shared bit-serial unit: two squares, a root,
// two products and two 64-step divisions, the last four skipped for a zero-length segment
// busy is high for the whole tick; results cannot be stalled
// reset clears all positions and sets gravity to 0.25
`include "verlet_rope_step_macros.svh"

module verlet_rope_step #(
  parameter int NUM_SEGMENTS = vrs_pkg::NumSegmentsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [3:0]         particle_index_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [8:0]  head_accel_x_i,
  input  logic [10:0]        seg_length_i,
  input  logic               gravity_accel_we_i,
  input  logic [7:0]         gravity_accel_i,
  output logic               out_valid_o,
  output logic [3:0]         out_index_o,
  output logic signed [23:0] out_x_o,
  output logic signed [23:0] out_y_o,
  output logic               last_particle_o
);

  localparam int NPart = NUM_SEGMENTS + 1;
  localparam int IW    = $clog2(NPart);
  localparam logic [IW-1:0] LastIdx = IW'(NUM_SEGMENTS);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_VERLET = 9'b000000010,
    S_RD1    = 9'b000000100,
    S_RD0    = 9'b000001000,
    S_CALC   = 9'b000010000,
    S_WAIT   = 9'b000100000,
    S_WR1    = 9'b001000000,
    S_WR0    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  typedef enum logic [2:0] {
    ST_SQX, ST_SQY, ST_SQRT, ST_MULX, ST_DIVX, ST_MULY, ST_DIVY
  } step_e;

  state_e state_q;
  step_e  step_q;

  logic signed [23:0] cur_x_q [NPart];
  logic signed [23:0] cur_y_q [NPart];
  logic signed [23:0] prev_x_q [NPart];
  logic signed [23:0] prev_y_q [NPart];

  logic [7:0]         grav_q;
  logic signed [23:0] anc_x_q, anc_y_q;
  logic signed [8:0]  hax_q;
  logic [10:0]        len_q;
  logic [IW-1:0]      vi_q, seg_q, pass_q;
  logic signed [23:0] ax_q, ay_q, bx_q, by_q;
  logic [63:0]        acc_q;
  logic [24:0]        d_q;
  logic signed [27:0] cx_q, cy_q;

  vrs_pkg::unit_req_t req;
  logic               u_done;
  logic [63:0]        u_res;

  logic [IW-1:0]      ra;
  logic signed [23:0] rd_x, rd_y, rd_px, rd_py;
  logic signed [24:0] dx, dy;
  logic [24:0]        mdx, mdy;
  logic signed [26:0] e;
  logic [26:0]        me;
  logic signed [27:0] qv;
  logic               accept, last_seg, last_pass;
  logic signed [23:0] ox, oy, vx_new, vy_new;
  logic signed [8:0]  vax;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // single read address into the particle store
  always_comb begin
    unique case (state_q)
      S_RD0, S_WR0: ra = seg_q - IW'(1);
      S_RD1, S_WR1: ra = seg_q;
      default:      ra = vi_q;
    endcase
  end

  assign rd_x  = cur_x_q[ra];
  assign rd_y  = cur_y_q[ra];
  assign rd_px = prev_x_q[ra];
  assign rd_py = prev_y_q[ra];

  // Verlet update of one particle
  assign vax    = (vi_q == '0) ? hax_q : 9'sd0;
  assign ox     = rd_x;
  assign oy     = rd_y;
  assign vx_new = vrs_pkg::sat_pos(32'(ox) + 32'(ox) - 32'(rd_px) + 32'(vax));
  assign vy_new = vrs_pkg::sat_pos(32'(oy) + 32'(oy) - 32'(rd_py) + $signed({24'd0, grav_q}));

  // segment geometry
  assign dx  = 25'(ax_q) - 25'(bx_q);
  assign dy  = 25'(ay_q) - 25'(by_q);
  assign mdx = dx[24] ? 25'(-dx) : 25'(dx);
  assign mdy = dy[24] ? 25'(-dy) : 25'(dy);
  assign e   = $signed({2'b00, d_q}) - $signed({16'd0, len_q});
  assign me  = e[26] ? 27'(-e) : 27'(e);

  // signed rounded quotient from the divider
  always_comb begin
    if (step_q == ST_DIVX) qv = (dx[24] ^ e[26]) ? -$signed({1'b0, u_res[26:0]})
                                                 : $signed({1'b0, u_res[26:0]});
    else qv = (dy[24] ^ e[26]) ? -$signed({1'b0, u_res[26:0]})
                               : $signed({1'b0, u_res[26:0]});
  end

  assign last_seg  = (seg_q == LastIdx);
  assign last_pass = (pass_q == LastIdx);

  // request to the shared unit
  always_comb begin
    req.start = (state_q == S_CALC);
    req.op    = vrs_pkg::UOP_MUL;
    req.a     = 64'(mdx);
    req.b     = 64'(mdx);
    unique case (step_q)
      ST_SQX:  begin req.a = 64'(mdx); req.b = 64'(mdx); end
      ST_SQY:  begin req.a = 64'(mdy); req.b = 64'(mdy); end
      ST_SQRT: begin req.op = vrs_pkg::UOP_SQRT; req.a = acc_q; req.b = '0; end
      ST_MULX: begin req.a = 64'(mdx); req.b = 64'(me); end
      ST_MULY: begin req.a = 64'(mdy); req.b = 64'(me); end
      ST_DIVX, ST_DIVY: begin
        req.op = vrs_pkg::UOP_DIV;
        req.a  = acc_q + 64'(d_q);
        req.b  = {38'd0, d_q, 1'b0};
      end
      default: req.start = 1'b0;
    endcase
  end

  vrs_serial u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (u_done),
    .res_o  (u_res)
  );

  // sequencer and particle store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= ST_SQX;
      grav_q  <= vrs_pkg::GravReset;
      vi_q    <= '0;
      seg_q   <= IW'(1);
      pass_q  <= '0;
      for (int i = 0; i < NPart; i++) begin
        cur_x_q[i]  <= '0;
        cur_y_q[i]  <= '0;
        prev_x_q[i] <= '0;
        prev_y_q[i] <= '0;
      end
    end else begin
      if (gravity_accel_we_i) grav_q <= gravity_accel_i;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (op_i == vrs_pkg::OpLoad) begin
              if (32'(particle_index_i) <= NUM_SEGMENTS) begin
                cur_x_q[IW'(particle_index_i)]  <= pos_x_i;
                prev_x_q[IW'(particle_index_i)] <= pos_x_i;
                cur_y_q[IW'(particle_index_i)]  <= pos_y_i;
                prev_y_q[IW'(particle_index_i)] <= pos_y_i;
              end
            end else begin
              anc_x_q <= pos_x_i;
              anc_y_q <= pos_y_i;
              hax_q   <= head_accel_x_i;
              len_q   <= seg_length_i;
              vi_q    <= '0;
              state_q <= S_VERLET;
            end
          end
        end
        S_VERLET: begin
          if (vi_q == LastIdx) begin
            // anchor pinned, old position too
            cur_x_q[ra]  <= anc_x_q;
            cur_y_q[ra]  <= anc_y_q;
            prev_x_q[ra] <= anc_x_q;
            prev_y_q[ra] <= anc_y_q;
            seg_q   <= IW'(1);
            pass_q  <= '0;
            state_q <= S_RD1;
          end else begin
            cur_x_q[ra]  <= vx_new;
            cur_y_q[ra]  <= vy_new;
            prev_x_q[ra] <= ox;
            prev_y_q[ra] <= oy;
            vi_q <= vi_q + IW'(1);
          end
        end
        S_RD1: begin
          ax_q    <= rd_x;
          ay_q    <= rd_y;
          state_q <= S_RD0;
        end
        S_RD0: begin
          bx_q    <= rd_x;
          by_q    <= rd_y;
          step_q  <= ST_SQX;
          state_q <= S_CALC;
        end
        S_CALC: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (u_done) begin
            state_q <= S_CALC;
            unique case (step_q)
              ST_SQX:  begin acc_q <= u_res; step_q <= ST_SQY; end
              ST_SQY:  begin acc_q <= acc_q + u_res; step_q <= ST_SQRT; end
              ST_SQRT: begin
                d_q    <= u_res[24:0];
                step_q <= ST_MULX;
                if (u_res == '0) begin
                  // zero-length segment: no correction
                  state_q <= S_WR0;
                  cx_q    <= '0;
                  cy_q    <= '0;
                end
              end
              ST_MULX: begin acc_q <= u_res; step_q <= ST_DIVX; end
              ST_DIVX: begin cx_q <= qv; step_q <= ST_MULY; end
              ST_MULY: begin acc_q <= u_res; step_q <= ST_DIVY; end
              ST_DIVY: begin cy_q <= qv; state_q <= S_WR1; end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_WR1: begin
          cur_x_q[ra] <= vrs_pkg::sat_pos(32'(ax_q) - 32'(cx_q));
          cur_y_q[ra] <= vrs_pkg::sat_pos(32'(ay_q) - 32'(cy_q));
          state_q     <= S_WR0;
        end
        S_WR0: begin
          cur_x_q[ra] <= vrs_pkg::sat_pos(32'(bx_q) + 32'(cx_q));
          cur_y_q[ra] <= vrs_pkg::sat_pos(32'(by_q) + 32'(cy_q));
          // next segment, next pass or report
          if (!last_seg) begin
            seg_q   <= seg_q + IW'(1);
            state_q <= S_RD1;
          end else if (!last_pass) begin
            seg_q   <= IW'(1);
            pass_q  <= pass_q + IW'(1);
            state_q <= S_RD1;
          end else begin
            vi_q    <= '0;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (vi_q == LastIdx) state_q <= S_IDLE;
          else vi_q <= vi_q + IW'(1);
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result transfer
  assign out_valid_o     = (state_q == S_OUT);
  assign out_index_o     = 4'(vi_q);
  assign out_x_o         = rd_x;
  assign out_y_o         = rd_y;
  assign last_particle_o = out_valid_o && (vi_q == LastIdx);

  `VRS_ASSERT_IMP(a_out_in_tick, out_valid_o, busy)
  `VRS_ASSERT_IMP(a_last_marked, last_particle_o, out_valid_o)
  `VRS_ASSERT_NXT(a_tick_busy, accept && (op_i == vrs_pkg::OpTick), busy)
  `VRS_ASSERT_IMP(a_unit_done_wait, u_done, state_q == S_WAIT)

endmodule

>>> bench/tb_verlet_rope_step.sv
// tb_verlet_rope_step: self-checking bench for the rope step core, with its own rope predictor
// depends on vrs_pkg and verlet_rope_step

module tb_verlet_rope_step;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSeg   = 10;
  localparam int NPart  = NSeg + 1;
  localparam longint PosMax = 64'sd8388607;
  localparam longint PosMin = -64'sd8388608;
  localparam longint CycleLimit = 64'd20_000_000;

  typedef struct {
    logic [3:0]         index;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               last;
  } particle_rpt_t;

  // rope predictor and store of expected particle reports
  class rope_scoreboard;
    longint        px[NPart], py[NPart], ox[NPart], oy[NPart];
    longint        gravity;
    particle_rpt_t pending[$];
    int            errors;

    function new();
      gravity = vrs_pkg::GravReset;
      errors  = 0;
      for (int i = 0; i < NPart; i++) begin
        px[i] = 0; py[i] = 0; ox[i] = 0; oy[i] = 0;
      end
    endfunction

    function longint clamp(longint v);
      if (v > PosMax) return PosMax;
      if (v < PosMin) return PosMin;
      return v;
    endfunction

    function longint root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    // num / (2*d), rounded to nearest with ties away from zero
    function longint half_div(longint num, longint d);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + d) / (2 * d);
      return (num < 0) ? -q : q;
    endfunction

    function void relax_pass(longint len);
      longint dx, dy, d, cx, cy;
      for (int i = 1; i < NPart; i++) begin
        dx = px[i] - px[i-1];
        dy = py[i] - py[i-1];
        d  = root_floor(dx * dx + dy * dy);
        if (d != 0) begin
          cx = half_div(dx * (d - len), d);
          cy = half_div(dy * (d - len), d);
          px[i]   = clamp(px[i] - cx);
          py[i]   = clamp(py[i] - cy);
          px[i-1] = clamp(px[i-1] + cx);
          py[i-1] = clamp(py[i-1] + cy);
        end
      end
    endfunction

    // accepted input transfer: update rope, queue reports on a tick
    function void note_item(logic opv, logic [3:0] idx, logic signed [23:0] ax_pos,
                            logic signed [23:0] ay_pos, logic signed [8:0] hax,
                            logic [10:0] len);
      longint tx, ty, acc;
      particle_rpt_t r;
      if (opv == vrs_pkg::OpLoad) begin
        if (idx < NPart) begin
          px[idx] = ax_pos; ox[idx] = ax_pos;
          py[idx] = ay_pos; oy[idx] = ay_pos;
        end
        return;
      end
      px[NSeg] = ax_pos;
      py[NSeg] = ay_pos;
      for (int i = 0; i < NPart; i++) begin
        tx = px[i];
        ty = py[i];
        acc = (i == 0) ? longint'(hax) : 0;
        px[i] = clamp(tx + (tx - ox[i]) + acc);
        py[i] = clamp(ty + (ty - oy[i]) + gravity);
        ox[i] = tx;
        oy[i] = ty;
      end
      px[NSeg] = ax_pos;
      py[NSeg] = ay_pos;
      for (int k = 0; k < NPart; k++) relax_pass(longint'(len));
      for (int i = 0; i < NPart; i++) begin
        r.index = i[3:0];
        r.x     = px[i][23:0];
        r.y     = py[i][23:0];
        r.last  = (i == NSeg);
        pending.push_back(r);
      end
    endfunction

    function void check_report(logic [3:0] idx, logic signed [23:0] xv,
                               logic signed [23:0] yv, logic lastv);
      particle_rpt_t e;
      if (pending.size() == 0) begin
        $error("unexpected report: out_index %0d x %0d y %0d", idx, xv, yv);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (idx !== e.index) begin
        $error("out_index: expected %0d, got %0d", e.index, idx); errors++;
      end
      if (xv !== e.x) begin
        $error("out_x: expected %0d, got %0d", e.x, xv); errors++;
      end
      if (yv !== e.y) begin
        $error("out_y: expected %0d, got %0d", e.y, yv); errors++;
      end
      if (lastv !== e.last) begin
        $error("last_particle: expected %0d, got %0d", e.last, lastv); errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               op_i = 1'b0;
  logic [3:0]         particle_index_i = '0;
  logic signed [23:0] pos_x_i = '0;
  logic signed [23:0] pos_y_i = '0;
  logic signed [8:0]  head_accel_x_i = '0;
  logic [10:0]        seg_length_i = 11'd768;
  logic               gravity_accel_we_i = 1'b0;
  logic [7:0]         gravity_accel_i = '0;
  logic               out_valid_o;
  logic [3:0]         out_index_o;
  logic signed [23:0] out_x_o;
  logic signed [23:0] out_y_o;
  logic               last_particle_o;

  rope_scoreboard rope_sb = new();
  longint         cycles = 0;
  int             idle_pct = 0;

  verlet_rope_step #(.NUM_SEGMENTS(NSeg)) DUT (
    .clk_i, .rst_ni, .start, .busy, .op_i, .particle_index_i, .pos_x_i, .pos_y_i,
    .head_accel_x_i, .seg_length_i, .gravity_accel_we_i, .gravity_accel_i,
    .out_valid_o, .out_index_o, .out_x_o, .out_y_o, .last_particle_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result transfers and run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o)
      rope_sb.check_report(out_index_o, out_x_o, out_y_o, last_particle_o);
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one input transfer, with an optional idle gap first
  task automatic send_item(logic opv, logic [3:0] idx, logic signed [23:0] xv,
                           logic signed [23:0] yv, logic signed [8:0] hax,
                           logic [10:0] len);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_i <= opv;
    particle_index_i <= idx;
    pos_x_i <= xv;
    pos_y_i <= yv;
    head_accel_x_i <= hax;
    seg_length_i <= len;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    rope_sb.note_item(opv, idx, xv, yv, hax, len);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (rope_sb.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_gravity(logic [7:0] g);
    gravity_accel_we_i <= 1'b1;
    gravity_accel_i <= g;
    @(posedge clk_i);
    gravity_accel_we_i <= 1'b0;
    rope_sb.gravity = g;
  endtask

  function automatic logic signed [23:0] near(int centre, int span);
    return 24'(centre + $urandom_range(2 * span) - span);
  endfunction

  function automatic logic [10:0] rand_len();
    return 11'($urandom_range(768, 1792));
  endfunction

  function automatic logic signed [8:0] rand_hax();
    return 9'($urandom_range(256) - 128);
  endfunction

  // a loaded rope hanging from a random point, then a few ticks
  task automatic rope_burst();
    int bx, by, n;
    bx = $urandom_range(200000) - 100000;
    by = $urandom_range(200000) - 100000;
    for (int i = 0; i < NPart; i++)
      send_item(vrs_pkg::OpLoad, i[3:0], near(bx, 300), near(by - 1024 * (NSeg - i), 300),
                rand_hax(), rand_len());
    n = $urandom_range(1, 3);
    for (int k = 0; k < n; k++)
      send_item(vrs_pkg::OpTick, 4'($urandom), near(bx, 400), near(by, 400), rand_hax(),
                rand_len());
  endtask

  task automatic noise_item();
    logic [3:0] idx;
    idx = 4'($urandom);
    if ($urandom_range(99) < 35)
      send_item(vrs_pkg::OpTick, idx, 24'($urandom), 24'($urandom), rand_hax(), rand_len());
    else
      send_item(vrs_pkg::OpLoad, idx, 24'($urandom), 24'($urandom), rand_hax(), rand_len());
  endtask

  initial begin
    logic [7:0] grav_set[4];
    int         count;
    grav_set = '{8'd0, 8'd255, 8'd64, 8'($urandom)};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes, out-of-range loads, zero-length segments
    write_gravity(8'd0);
    send_item(vrs_pkg::OpTick, 4'd0, 24'sd0, 24'sd0, 9'sd0, 11'd768);
    for (int i = 11; i < 16; i++)
      send_item(vrs_pkg::OpLoad, i[3:0], 24'sh7FFFFF, 24'sh800000, 9'sd0, 11'd768);
    send_item(vrs_pkg::OpLoad, 4'd0, 24'sh7FFFFF, 24'sh7FFFFF, 9'sd0, 11'd768);
    send_item(vrs_pkg::OpLoad, 4'd5, 24'sh800000, 24'sh800000, 9'sd0, 11'd768);
    send_item(vrs_pkg::OpTick, 4'd15, 24'sh800000, 24'sh7FFFFF, 9'sd128, 11'd1792);
    send_item(vrs_pkg::OpTick, 4'd0, 24'sh7FFFFF, 24'sh800000, -9'sd128, 11'd768);
    send_item(vrs_pkg::OpTick, 4'd3, 24'sd0, 24'sd0, -9'sd1, 11'h7FF & 11'd1791);
    wait_idle();
    write_gravity(8'd255);
    send_item(vrs_pkg::OpTick, 4'd0, 24'sd1000, -24'sd1000, 9'sd127, 11'd1024);
    send_item(vrs_pkg::OpTick, 4'd0, 24'sh7FFFFF, 24'sh7FFFFF, 9'sd128, 11'd1792);
    wait_idle();

    // random phases: idling and gravity setting change per phase
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_gravity(grav_set[ph]);
      idle_pct = (ph == 1) ? 51 : (ph == 3) ? 14 : 0;
      count = 0;
      while (count < 42) begin
        if ($urandom_range(99) < 70) begin
          rope_burst();
          count += 13;
        end else begin
          noise_item();
          count++;
        end
      end
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (rope_sb.errors == 0 && rope_sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
